// ----- src/dsk_pkg.sv -----
// ----------------------------------------------------------------------------
// DES key schedule package
// Permuted choice tables, the rotation schedule and shared types.
// ----------------------------------------------------------------------------
package dsk_pkg;

  localparam int KEY_W    = 64;
  localparam int HALF_W   = 28;
  localparam int CD_W     = 56;
  localparam int SUBKEY_W = 48;
  localparam int ROUND_W  = 4;
  localparam int OUT_TDATA_W = 56;

  localparam logic [ROUND_W-1:0] LAST_ROUND = 4'd15;

  // Bit r is set where round r rotates by two places instead of one.
  localparam logic [15:0] ROT_TWO = 16'b0111_1110_1111_1100;

  localparam logic [6:0] PC1_TABLE [CD_W] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [5:0] PC2_TABLE [SUBKEY_W] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
    6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
    6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
    6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
    6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  typedef struct packed {
    logic                valid;
    logic [CD_W-1:0]     cd;
    logic [ROUND_W-1:0]  round;
    logic                last;
  } dsk_issue_t;

  function automatic logic [CD_W-1:0] pc1(input logic [KEY_W-1:0] key);
    logic [CD_W-1:0] r;
    r = '0;
    for (int i = 0; i < CD_W; i++) begin
      r[CD_W-1-i] = key[6'(KEY_W - int'(PC1_TABLE[i]))];
    end
    return r;
  endfunction

  function automatic logic [SUBKEY_W-1:0] pc2(input logic [CD_W-1:0] cd);
    logic [SUBKEY_W-1:0] r;
    r = '0;
    for (int i = 0; i < SUBKEY_W; i++) begin
      r[SUBKEY_W-1-i] = cd[6'(CD_W - int'(PC2_TABLE[i]))];
    end
    return r;
  endfunction

  function automatic logic [HALF_W-1:0] rotl_half(input logic [HALF_W-1:0] v,
                                                  input logic two);
    return two ? {v[HALF_W-3:0], v[HALF_W-1:HALF_W-2]}
               : {v[HALF_W-2:0], v[HALF_W-1]};
  endfunction

endpackage

// ----- src/dsk_sched.sv -----
// ----------------------------------------------------------------------------
// DES key schedule round sequencer
// Holds the C and D halves of one key and rotates them once per round.
// ----------------------------------------------------------------------------
module dsk_sched
  import dsk_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             key_valid,
  output logic             key_ready,
  input  logic [KEY_W-1:0] key,
  input  logic             issue_ready,
  output dsk_issue_t       issue
);

  logic               busy_r, busy_nxt;
  logic [ROUND_W-1:0] round_r, round_nxt;
  logic [HALF_W-1:0]  c_r, c_nxt, d_r, d_nxt;
  logic [HALF_W-1:0]  c_rot, d_rot;
  logic [CD_W-1:0]    key_cd;
  logic               advance, take;

  assign c_rot   = rotl_half(c_r, ROT_TWO[round_r]);
  assign d_rot   = rotl_half(d_r, ROT_TWO[round_r]);
  assign advance = busy_r && issue_ready;
  assign key_ready = !busy_r || (advance && (round_r == LAST_ROUND));
  assign take    = key_valid && key_ready;
  assign key_cd  = pc1(key);

  assign issue.valid = busy_r;
  assign issue.cd    = {c_rot, d_rot};
  assign issue.round = round_r;
  assign issue.last  = (round_r == LAST_ROUND);

  always_comb begin
    busy_nxt  = busy_r;
    round_nxt = round_r;
    c_nxt     = c_r;
    d_nxt     = d_r;
    if (advance) begin
      c_nxt     = c_rot;
      d_nxt     = d_rot;
      round_nxt = round_r + 4'd1;
      if (round_r == LAST_ROUND) begin
        busy_nxt = 1'b0;
      end
    end
    if (take) begin
      busy_nxt  = 1'b1;
      round_nxt = '0;
      c_nxt     = key_cd[CD_W-1:HALF_W];
      d_nxt     = key_cd[HALF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      round_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      round_r <= round_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r <= c_nxt;
    d_r <= d_nxt;
  end

endmodule

// ----- src/des_subkey_generator.sv -----
// ----------------------------------------------------------------------------
// DES subkey generator
// Turns each 64-bit DES key into its sixteen 48-bit round subkeys.
// ----------------------------------------------------------------------------
// Channel   Ports                        Contents
// in        in_tvalid/tready/tdata       one key per transaction
// out       out_tvalid/tready/tdata/tlast one subkey per transaction, tlast on round 16
//
// Each key yields sixteen subkeys, one per round, from the single round
// rotator. The next key is taken in the cycle the sixteenth subkey is issued,
// so keys follow without gaps. Subkeys appear in the cycle after issue, through
// the output register. Reset clears the sequencer and the output valid flag.
// A stalled output holds the rotator and the output register.
// ----------------------------------------------------------------------------
module des_subkey_generator
  import dsk_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [KEY_W-1:0]       in_tdata,    // [63:0] key
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,   // [47:0] subkey, [51:48] round, rest zero
  output logic                   out_tlast
);

  dsk_issue_t              issue;
  logic                    issue_ready;
  logic                    out_valid_r, out_valid_nxt;
  logic [SUBKEY_W-1:0]     subkey_r;
  logic [ROUND_W-1:0]      round_r;
  logic                    last_r;

  dsk_sched u_sched (
    .clk         (clk),
    .rst_n       (rst_n),
    .key_valid   (in_tvalid),
    .key_ready   (in_tready),
    .key         (in_tdata),
    .issue_ready (issue_ready),
    .issue       (issue)
  );

  assign issue_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (issue_ready) begin
      out_valid_nxt = issue.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_ready && issue.valid) begin
      subkey_r <= pc2(issue.cd);
      round_r  <= issue.round;
      last_r   <= issue.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-SUBKEY_W-ROUND_W){1'b0}}, round_r, subkey_r};
  assign out_tlast  = last_r;

endmodule
